// File: design/binary_to_radix_digits_top_defines.svh
// Assertion macros shared by the radix converter RTL.
`ifndef BINARY_TO_RADIX_DIGITS_TOP_DEFINES_SVH
`define BINARY_TO_RADIX_DIGITS_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define RDX_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RDX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define RDX_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define RDX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: design/rdx_pkg.sv
// Shared constants, types and functions of the radix digit converter.
`default_nettype none

package rdx_pkg;

    // Default width of the converted value.
    localparam int VALUE_BITS_DEF = 32;
    // Quotient bits resolved by the divider in one cycle.
    localparam int CHUNK_BITS = 8;
    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    // One result item as it sits in the output queue.
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               final_digit;
    } t_out_item;

    // Clamp the radix register into the supported range.
    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] raw);
        logic [RADIX_W-1:0] r;
        r = raw;
        if (raw < RADIX_MIN) begin
            r = RADIX_MIN;
        end else if (raw > RADIX_MAX) begin
            r = RADIX_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/rdx_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rdx_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: design/rdx_fifo.sv
// Two-entry queue used for job hand-off and for buffering result items.
`default_nettype none

module rdx_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty,
    output logic                  o_full,
    output logic      [1:0]       o_count
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic             n_wptr;
    logic             n_rptr;
    logic [1:0]       n_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and occupancy update.
    always_comb begin
        n_wptr  = do_push ? ~r_wptr : r_wptr;
        n_rptr  = do_pop ? ~r_rptr : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: design/rdx_front.sv
// Front end: accepts a value and divides it down into digits, least significant first.
`default_nettype none

module rdx_front import rdx_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire logic [VALUE_BITS-1:0]         i_value,
    input  wire logic [RADIX_W-1:0]            i_radix,
    input  wire logic                          i_space,
    output logic                               o_full,
    output logic                               o_job_push,
    output logic      [$clog2(VALUE_BITS):0]   o_job_count,
    output logic                               o_wr_en,
    output logic      [$clog2(VALUE_BITS):0]   o_wr_addr,
    output logic      [DIGIT_W-1:0]            o_wr_data
);

    localparam int IDX_W = $clog2(VALUE_BITS);
    localparam int CNT_W = IDX_W + 1;
    localparam int QW    = ((VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS) * CHUNK_BITS;
    localparam int NCH   = QW / CHUNK_BITS;
    localparam int CH_W  = (NCH > 1) ? $clog2(NCH) : 1;

    typedef enum logic [1:0] {
        FR_IDLE = 2'b01,
        FR_DIV  = 2'b10
    } t_fr_state;

    t_fr_state          r_state, n_state;
    logic               r_bank, n_bank;
    logic [QW-1:0]      r_quo, n_quo;
    logic [DIGIT_W-1:0] r_rem, n_rem;
    logic [RADIX_W-1:0] r_radix, n_radix;
    logic               r_nz, n_nz;
    logic [CH_W-1:0]    r_chunk, n_chunk;
    logic [IDX_W-1:0]   r_ndig, n_ndig;

    logic [CHUNK_BITS-1:0] qbits;
    logic [DIGIT_W-1:0]    rem_step;
    logic                  chunk_last;
    logic                  quo_nz;
    logic                  accept;

    assign o_full = (r_state != FR_IDLE) || !i_space;
    assign accept = i_push && !o_full;

    // One chunk of restoring division by the radix: eight quotient bits.
    always_comb begin
        logic [DIGIT_W:0]   t;
        logic [DIGIT_W-1:0] rem;
        rem   = r_rem;
        qbits = '0;
        for (int i = 0; i < CHUNK_BITS; i++) begin
            t = {rem, r_quo[QW-1-i]};
            if (t >= r_radix) begin
                qbits[CHUNK_BITS-1-i] = 1'b1;
                t = t - r_radix;
            end
            rem = t[DIGIT_W-1:0];
        end
        rem_step = rem;
    end

    assign chunk_last = (r_chunk == CH_W'(NCH - 1));
    assign quo_nz     = r_nz || (|qbits);

    // Digit write at the end of each digit; job hand-off after the last digit.
    assign o_wr_en     = (r_state == FR_DIV) && chunk_last;
    assign o_wr_addr   = {r_bank, r_ndig};
    assign o_wr_data   = rem_step;
    assign o_job_push  = o_wr_en && !quo_nz;
    assign o_job_count = CNT_W'({1'b0, r_ndig}) + CNT_W'(1);

    // Sequencer of the divider.
    always_comb begin
        n_state = r_state;
        n_bank  = r_bank;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_radix = r_radix;
        n_nz    = r_nz;
        n_chunk = r_chunk;
        n_ndig  = r_ndig;
        case (r_state)
            FR_IDLE: begin
                if (accept) begin
                    n_state = FR_DIV;
                    n_quo   = QW'(i_value);
                    n_rem   = '0;
                    n_radix = eff_radix(i_radix);
                    n_nz    = 1'b0;
                    n_chunk = '0;
                    n_ndig  = '0;
                end
            end
            FR_DIV: begin
                n_quo = (r_quo << CHUNK_BITS) | QW'(qbits);
                if (chunk_last) begin
                    n_rem   = '0;
                    n_nz    = 1'b0;
                    n_chunk = '0;
                    if (quo_nz) begin
                        n_ndig = r_ndig + IDX_W'(1);
                    end else begin
                        n_state = FR_IDLE;
                        n_bank  = ~r_bank;
                    end
                end else begin
                    n_rem   = rem_step;
                    n_nz    = quo_nz;
                    n_chunk = r_chunk + CH_W'(1);
                end
            end
            default: begin
                n_state = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
            r_bank  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bank  <= n_bank;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_radix <= n_radix;
        r_nz    <= n_nz;
        r_chunk <= n_chunk;
        r_ndig  <= n_ndig;
    end

endmodule

`default_nettype wire

// File: design/rdx_back.sv
// Back end: reads the stored digits most significant first and queues result items.
`default_nettype none

module rdx_back import rdx_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_job_empty,
    input  wire logic [$clog2(VALUE_BITS):0]   i_job_count,
    output logic                               o_job_pop,
    output logic                               o_rd_en,
    output logic      [$clog2(VALUE_BITS):0]   o_rd_addr,
    input  wire logic [DIGIT_W-1:0]            i_rd_data,
    output logic                               o_active,
    input  wire logic                          i_pop,
    output logic                               o_empty,
    output logic      [DIGIT_W-1:0]            o_digit,
    output logic                               o_final_digit
);

    localparam int IDX_W = $clog2(VALUE_BITS);

    logic             r_active, n_active;
    logic             r_bank, n_bank;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_infl, n_infl;
    logic             r_inf_final, n_inf_final;

    logic      can_issue;
    logic      of_full;
    logic [1:0] of_count;
    t_out_item of_in;
    t_out_item of_out;

    // A read is issued only if its data will find room in the output queue.
    assign can_issue = !of_full && !((of_count == 2'd1) && r_infl);

    assign o_job_pop = !r_active && !i_job_empty;
    assign o_rd_en   = r_active && can_issue;
    assign o_rd_addr = {r_bank, r_idx};
    assign o_active  = r_active;

    // Run control: load a job, then count the digit index down to zero.
    always_comb begin
        n_active    = r_active;
        n_bank      = r_bank;
        n_idx       = r_idx;
        n_infl      = o_rd_en;
        n_inf_final = r_inf_final;
        if (o_job_pop) begin
            n_active = 1'b1;
            n_idx    = IDX_W'(i_job_count - 1'b1);
        end
        if (o_rd_en) begin
            n_inf_final = (r_idx == '0);
            if (r_idx == '0) begin
                n_active = 1'b0;
                n_bank   = ~r_bank;
            end else begin
                n_idx = r_idx - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_bank   <= 1'b0;
            r_infl   <= 1'b0;
        end else begin
            r_active <= n_active;
            r_bank   <= n_bank;
            r_infl   <= n_infl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_inf_final <= n_inf_final;
    end

    // Output queue holds read digits until they are taken.
    always_comb begin
        of_in.digit       = i_rd_data;
        of_in.final_digit = r_inf_final;
    end

    rdx_fifo #(
        .WIDTH($bits(t_out_item))
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_infl),
        .i_data  (of_in),
        .i_pop   (i_pop),
        .o_data  (of_out),
        .o_empty (o_empty),
        .o_full  (of_full),
        .o_count (of_count)
    );

    assign o_digit       = of_out.digit;
    assign o_final_digit = of_out.final_digit;

endmodule

`default_nettype wire

// File: design/binary_to_radix_digits_top.sv
// Top level of the binary to radix digit converter.
//
//   Channel  Direction  Handshake           Payload
//   input    in         i_push / o_full     i_value
//   result   out        o_empty / i_pop     o_digit, o_final_digit
//   config   in         i_cfg_we            i_cfg_wdata (radix)
//
// The divider resolves 8 quotient bits per cycle and divides the value by the radix once
// for each digit. The back end reads the digits back from the digit RAM only while the
// output queue has room for the data, counting a read still in flight, so it can issue
// a new read before the last one has landed.
// The front may run up to two converted items ahead of the back end.
// Reset is synchronous and clears control state only; the digit RAM is not cleared.
`default_nettype none
`include "binary_to_radix_digits_top_defines.svh"

module binary_to_radix_digits_top import rdx_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    output logic                       o_full,
    input  wire logic [VALUE_BITS-1:0] i_value,
    output logic                       o_empty,
    input  wire logic                  i_pop,
    output logic      [DIGIT_W-1:0]    o_digit,
    output logic                       o_final_digit,
    input  wire logic                  i_cfg_we,
    input  wire logic [RADIX_W-1:0]    i_cfg_wdata
);

    localparam int IDX_W  = $clog2(VALUE_BITS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int ADDR_W = IDX_W + 1;

    logic [RADIX_W-1:0] r_radix;

    logic               fr_space;
    logic               fr_job_push;
    logic [CNT_W-1:0]   fr_job_count;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [DIGIT_W-1:0] wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [DIGIT_W-1:0] rd_data;
    logic               jq_empty;
    logic               jq_full;
    logic [1:0]         jq_count;
    logic [CNT_W-1:0]   jq_data;
    logic               bk_job_pop;
    logic               bk_active;

    // Radix register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_wdata;
        end
    end

    // A RAM bank is free while fewer than two converted items are pending.
    assign fr_space = (jq_count == 2'd0) || ((jq_count == 2'd1) && !bk_active);

    rdx_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_value     (i_value),
        .i_radix     (r_radix),
        .i_space     (fr_space),
        .o_full      (o_full),
        .o_job_push  (fr_job_push),
        .o_job_count (fr_job_count),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    // Two banks of digit storage, one per pending item.
    rdx_ram #(
        .WIDTH(DIGIT_W),
        .DEPTH(2 ** ADDR_W)
    ) u_digit_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Job queue carries digit counts from front to back.
    rdx_fifo #(
        .WIDTH(CNT_W)
    ) u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_job_push),
        .i_data  (fr_job_count),
        .i_pop   (bk_job_pop),
        .o_data  (jq_data),
        .o_empty (jq_empty),
        .o_full  (jq_full),
        .o_count (jq_count)
    );

    rdx_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_empty   (jq_empty),
        .i_job_count   (jq_data),
        .o_job_pop     (bk_job_pop),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_active      (bk_active),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_digit       (o_digit),
        .o_final_digit (o_final_digit)
    );

    // The job queue never overflows because the front waits for a free bank.
    `RDX_ASSERT_NOW(a_job_no_overflow, i_clk, i_rst_n, fr_job_push, !jq_full)

    // At most two items hold RAM banks at any time.
    `RDX_ASSERT_NOW(a_bank_budget, i_clk, i_rst_n, 1'b1, ({1'b0, jq_count} + {2'b00, bk_active}) <= 3'd2)

    // An accepted item keeps the front busy in the following cycle.
    `RDX_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_push && !o_full, o_full)

    // The back end only starts a run when a job is queued.
    `RDX_ASSERT_NOW(a_pop_has_job, i_clk, i_rst_n, bk_job_pop, !jq_empty && !bk_active)

endmodule

`default_nettype wire

// File: verif/tb_binary_to_radix_digits_top.sv
// Self-checking testbench for the radix digit converter, checked digit by digit.
`timescale 1ns / 1ps

module tb_binary_to_radix_digits_top import rdx_pkg::*;;

    // Kinds of entries in the stimulus list.
    typedef enum logic [1:0] {
        JOB_ITEM,
        JOB_RADIX,
        JOB_DRAIN
    } t_job_kind;

    typedef struct {
        t_job_kind          kind;
        logic [31:0]        value;
        logic [RADIX_W-1:0] radix;
    } t_job;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_push = 1'b0;
    logic               o_full;
    logic [31:0]        i_value = '0;
    logic               o_empty;
    logic               i_pop = 1'b0;
    logic [DIGIT_W-1:0] o_digit;
    logic               o_final_digit;
    logic               i_cfg_we = 1'b0;
    logic [RADIX_W-1:0] i_cfg_wdata = '0;

    t_job               pending[$];
    t_out_item          digits_due[$];
    logic [RADIX_W-1:0] radix_model = RADIX_RESET;
    int                 mismatches = 0;
    int                 send_wait = 0;
    int                 pop_wait = 0;
    bit                 send_calm = 1'b0;
    bit                 pop_calm = 1'b0;
    logic               drained = 1'b1;
    logic               all_sent = 1'b0;

    binary_to_radix_digits_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_value       (i_value),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_digit       (o_digit),
        .o_final_digit (o_final_digit),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Idle cycles before the next item on one side; calm stretches have none.
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 15) == 0) begin
            calm = ~calm;
        end
        return calm ? 0 : int'($urandom_range(0, 17));
    endfunction

    // Divide by the clamped radix and queue the digits, most significant first.
    function automatic void predict_digits(input logic [31:0] value,
                                           input logic [RADIX_W-1:0] radix_reg);
        logic [31:0]        rest;
        logic [31:0]        base;
        logic [DIGIT_W-1:0] rems[32];
        int                 count;
        t_out_item          entry;
        base = radix_reg;
        if (radix_reg < RADIX_MIN) begin
            base = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            base = RADIX_MAX;
        end
        rest = value;
        count = 0;
        do begin
            rems[count] = DIGIT_W'(rest % base);
            count++;
            rest = rest / base;
        end while (rest != 0);
        for (int k = count - 1; k >= 0; k--) begin
            entry.digit = rems[k];
            entry.final_digit = (k == 0);
            digits_due.push_back(entry);
        end
    endfunction

    task automatic add_item(input logic [31:0] value);
        pending.push_back(t_job'{kind: JOB_ITEM, value: value, radix: '0});
    endtask

    task automatic add_radix(input logic [RADIX_W-1:0] radix);
        pending.push_back(t_job'{kind: JOB_RADIX, value: '0, radix: radix});
    endtask

    task automatic add_drain();
        pending.push_back(t_job'{kind: JOB_DRAIN, value: '0, radix: '0});
    endtask

    // Driver: feeds items from the pending list; radix writes and pauses wait until drained.
    always @(posedge i_clk) begin : drive_items
        logic               nxt_push;
        logic [31:0]        nxt_value;
        logic               nxt_we;
        logic [RADIX_W-1:0] nxt_wdata;
        t_job               job;
        nxt_push = i_push;
        nxt_value = i_value;
        nxt_we = 1'b0;
        nxt_wdata = i_cfg_wdata;
        if (!i_rst_n) begin
            nxt_push = 1'b0;
            send_wait = 0;
        end else begin
            if (i_push && !o_full) begin
                nxt_push = 1'b0;
            end
            if (!nxt_push) begin
                if (send_wait != 0) begin
                    send_wait--;
                end else if (pending.size() != 0) begin
                    job = pending[0];
                    case (job.kind)
                        JOB_ITEM: begin
                            nxt_push = 1'b1;
                            nxt_value = job.value;
                            void'(pending.pop_front());
                            send_wait = draw_wait(send_calm);
                        end
                        JOB_RADIX: begin
                            if (drained && !i_push) begin
                                nxt_we = 1'b1;
                                nxt_wdata = job.radix;
                                void'(pending.pop_front());
                            end
                        end
                        default: begin
                            if (drained && !i_push) begin
                                void'(pending.pop_front());
                            end
                        end
                    endcase
                end
            end
        end
        i_push <= nxt_push;
        i_value <= nxt_value;
        i_cfg_we <= nxt_we;
        i_cfg_wdata <= nxt_wdata;
        all_sent <= i_rst_n && (pending.size() == 0) && !nxt_push && !nxt_we;
    end

    // Monitor: checks each popped digit, predicts accepted items, tracks the radix register.
    always @(posedge i_clk) begin : watch_results
        t_out_item want;
        logic      nxt_pop;
        nxt_pop = 1'b0;
        if (!i_rst_n) begin
            digits_due.delete();
            radix_model = RADIX_RESET;
            pop_wait = 0;
        end else begin
            if (i_pop && !o_empty) begin
                if (digits_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected digit %0h final %0b",
                                              o_digit, o_final_digit));
                end else begin
                    want = digits_due.pop_front();
                    if (o_digit !== want.digit) begin
                        report_mismatch($sformatf("digit %0h, expected %0h",
                                                  o_digit, want.digit));
                    end
                    if (o_final_digit !== want.final_digit) begin
                        report_mismatch($sformatf("final_digit %0b, expected %0b",
                                                  o_final_digit, want.final_digit));
                    end
                end
                pop_wait = draw_wait(pop_calm);
            end else if (pop_wait != 0) begin
                pop_wait--;
            end
            if (i_push && !o_full) begin
                predict_digits(i_value, radix_model);
            end
            if (i_cfg_we) begin
                radix_model = i_cfg_wdata;
            end
            nxt_pop = (pop_wait == 0);
        end
        i_pop <= nxt_pop;
        drained <= (digits_due.size() == 0);
    end

    // Stimulus, reset and end of run.
    initial begin : run_test
        logic [RADIX_W-1:0] radix;
        logic [31:0]        value;
        // Reset radix of ten, with both extremes of the value.
        add_item(32'd0);
        add_item(32'd9);
        add_item(32'd10);
        add_item(32'hFFFF_FFFF);
        add_item(32'd1234567890);
        // Radix zero and one clamp to binary; all ones gives the longest run.
        add_radix(5'd0);
        add_item(32'd0);
        add_item(32'd1);
        add_item(32'hFFFF_FFFF);
        add_item(32'h8000_0000);
        add_radix(5'd1);
        add_item(32'h5555_5555);
        // Hexadecimal, with every digit value appearing.
        add_radix(5'd16);
        add_item(32'h7654_3210);
        add_item(32'hFEDC_BA98);
        add_item(32'd15);
        // Radix above sixteen clamps to sixteen.
        add_radix(5'd31);
        add_item(32'hFFFF_FFFF);
        add_item(32'd16);
        add_radix(5'd17);
        add_item(32'h1000_0000);
        add_radix(5'd3);
        add_item(32'hFFFF_FFFF);
        add_item(32'd8);
        add_radix(5'd7);
        add_item(32'd48);
        add_drain();

        // Random phases, each under its own radix setting.
        for (int phase = 0; phase < 8; phase++) begin
            if ($urandom_range(0, 3) == 0) begin
                radix = RADIX_W'($urandom_range(0, 31));
            end else begin
                radix = RADIX_W'($urandom_range(2, 16));
            end
            add_radix(radix);
            for (int n = 0; n < 17; n++) begin
                case ($urandom_range(0, 4))
                    0: value = $urandom;
                    1: value = $urandom_range(0, 255);
                    2: value = $urandom >> $urandom_range(1, 31);
                    3: value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
                    default: value = $urandom_range(0, 65535);
                endcase
                add_item(value);
                if ($urandom_range(0, 24) == 0) begin
                    add_drain();
                end
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(all_sent && drained)) begin
            @(posedge i_clk);
        end
        repeat (200) @(posedge i_clk);
        if (digits_due.size() != 0) begin
            report_mismatch($sformatf("%0d digits never arrived", digits_due.size()));
        end
        if (mismatches == 0) begin
            $display("tb_binary_to_radix_digits_top OK");
        end else begin
            $display("tb_binary_to_radix_digits_top NOT OK");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #4_000_000;
        $display("TIMEOUT at %0t", $realtime);
        $display("tb_binary_to_radix_digits_top NOT OK");
        $finish;
    end

endmodule
